FILE: rtl/string_literal_unescape_macros.svh
// assertion macros for the string literal unescaper
`ifndef STRING_LITERAL_UNESCAPE_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_MACROS_SVH
// a condition that must hold at every edge outside reset
`define SLU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// a condition that implies another in the next cycle
`define SLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/slu_pkg.sv
// shared types, codes and helpers for the string literal unescaper
package slu_pkg;

  localparam int MaxRes = 6;
  localparam int QDepth = 8;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ESCAPE  = 3'd1;
  localparam logic [2:0] ERR_HEX     = 3'd2;
  localparam logic [2:0] ERR_UNICODE = 3'd3;
  localparam logic [2:0] ERR_UTF8    = 3'd4;
  localparam logic [2:0] ERR_UNTERM  = 3'd5;
  localparam logic [2:0] ERR_RQUOTE  = 3'd6;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_RSEEN  = 8'b0000_0010,
    PH_BODY   = 8'b0000_0100,
    PH_ESC    = 8'b0000_1000,
    PH_HEX    = 8'b0001_0000,
    PH_USTART = 8'b0010_0000,
    PH_U4     = 8'b0100_0000,
    PH_BRACE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_v;
    logic [2:0] err;
    logic       raw;
    logic       term;
    logic       last;
  } res_t;

  // one input beat's worth of results
  typedef struct packed {
    logic [2:0] count;
    res_t [MaxRes-1:0] res;
  } group_t;

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] b,
                              input logic [2:0] e, input logic raw, input logic t);
    res_t r;
    r.kind = k; r.byte_v = b; r.err = e; r.raw = raw; r.term = t; r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = {1'b1, b[3:0] + 4'd9};
    else v = 5'd0;
    return v;
  endfunction

endpackage

FILE: rtl/slu_front.sv
// front end: decodes each byte combinationally into its group of results
module slu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  logic [7:0]     in_byte,
  input  logic           end_of_input,
  output slu_pkg::group_t grp
);
  import slu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        raw_r, raw_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic        bf_r, bf_nxt;
  logic [7:0]  sb_r [3];
  logic [7:0]  sb_nxt [3];
  logic [1:0]  need_r, need_nxt, held_r, held_nxt;

  res_t [MaxRes-1:0] rs;
  logic [2:0] n;

  always_comb begin
    logic [7:0] b;
    logic [4:0] h;
    logic [23:0] cp;
    logic [7:0] lo, hi;
    logic go;
    b = in_byte;
    h = hex_val(b);
    phase_nxt = phase_r; raw_nxt = raw_r; acc_nxt = acc_r; dc_nxt = dc_r;
    bf_nxt = bf_r; need_nxt = need_r; held_nxt = held_r;
    sb_nxt = sb_r;
    rs = '0; n = 3'd0;
    cp = '0; lo = 8'h80; hi = 8'hBF; go = 1'b0;

    // results record raw_r, the current flag; raw only changes with no results pending
    if (end_of_input) begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_RSEEN: begin
          rs[0] = mk(KIND_ERR, 8'd0, ERR_RQUOTE, raw_r, 1'b0);
          rs[1] = mk(KIND_END, 8'd0, ERR_NONE, raw_r, 1'b0);
          n = 3'd2; phase_nxt = PH_IDLE;
        end
        default: begin
          if (phase_r == PH_HEX) begin
            if (dc_r == 3'd0) rs[n] = mk(KIND_ERR, 8'd0, ERR_HEX, raw_r, 1'b0);
            else rs[n] = mk(KIND_BYTE, acc_r[7:0], ERR_NONE, raw_r, 1'b0);
            n = n + 3'd1;
          end else if (phase_r == PH_USTART || phase_r == PH_U4 || phase_r == PH_BRACE) begin
            rs[n] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0);
            n = n + 3'd1;
          end
          for (int i = 0; i < 3; i++)
            if (2'(i) < held_r) begin
              rs[n] = mk(KIND_ERR, 8'd0, ERR_UTF8, raw_r, 1'b0);
              n = n + 3'd1;
            end
          held_nxt = 2'd0; need_nxt = 2'd0;
          rs[n] = mk(KIND_ERR, 8'd0, ERR_UNTERM, raw_r, 1'b0);
          rs[n+3'd1] = mk(KIND_END, 8'd0, ERR_NONE, raw_r, 1'b0);
          n = n + 3'd2; phase_nxt = PH_IDLE;
        end
      endcase
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b == 8'h22) begin raw_nxt = 1'b0; phase_nxt = PH_BODY; end
          else if (b == 8'h72) begin raw_nxt = 1'b1; phase_nxt = PH_RSEEN; end
        end
        PH_RSEEN: begin
          if (b == 8'h22) phase_nxt = PH_BODY;
          else begin
            rs[0] = mk(KIND_ERR, 8'd0, ERR_RQUOTE, raw_r, 1'b0);
            rs[1] = mk(KIND_END, 8'd0, ERR_NONE, raw_r, 1'b0);
            n = 3'd2; phase_nxt = PH_IDLE;
            if (b == 8'h22) ;
            else if (b == 8'h72) phase_nxt = PH_RSEEN;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_BODY; n = 3'd1;
          case (b)
            8'h6E: rs[0] = mk(KIND_BYTE, 8'h0A, ERR_NONE, raw_r, 1'b0);
            8'h74: rs[0] = mk(KIND_BYTE, 8'h09, ERR_NONE, raw_r, 1'b0);
            8'h72: rs[0] = mk(KIND_BYTE, 8'h0D, ERR_NONE, raw_r, 1'b0);
            8'h5C, 8'h22, 8'h27: rs[0] = mk(KIND_BYTE, b, ERR_NONE, raw_r, 1'b0);
            8'h30: rs[0] = mk(KIND_BYTE, 8'h00, ERR_NONE, raw_r, 1'b0);
            8'h78: begin
              n = 3'd0; phase_nxt = PH_HEX; acc_nxt = '0; dc_nxt = '0; bf_nxt = 1'b0;
            end
            8'h75: begin
              n = 3'd0; phase_nxt = PH_USTART; acc_nxt = '0; dc_nxt = '0; bf_nxt = 1'b0;
            end
            default: begin
              rs[0] = mk(KIND_ERR, 8'd0, ERR_ESCAPE, raw_r, 1'b0);
              rs[1] = mk(KIND_BYTE, b, ERR_NONE, raw_r, 1'b0);
              n = 3'd2;
            end
          endcase
        end
        PH_HEX: begin
          if (h[4]) begin
            acc_nxt = {16'd0, acc_r[3:0], h[3:0]};
            dc_nxt = dc_r + 3'd1;
            if (dc_r != 3'd0) begin
              rs[0] = mk(KIND_BYTE, {acc_r[3:0], h[3:0]}, ERR_NONE, raw_r, 1'b0);
              n = 3'd1; phase_nxt = PH_BODY;
            end
          end else begin
            if (dc_r == 3'd0) rs[0] = mk(KIND_ERR, 8'd0, ERR_HEX, raw_r, 1'b0);
            else rs[0] = mk(KIND_BYTE, acc_r[7:0], ERR_NONE, raw_r, 1'b0);
            n = 3'd1; phase_nxt = PH_BODY; go = 1'b1;
          end
        end
        PH_USTART, PH_U4: begin
          if (phase_r == PH_USTART && b == 8'h7B) begin
            phase_nxt = PH_BRACE; acc_nxt = '0; dc_nxt = '0; bf_nxt = 1'b0;
          end else if (h[4]) begin
            phase_nxt = PH_U4;
            acc_nxt = {8'd0, acc_r[11:0], h[3:0]};
            dc_nxt = dc_r + 3'd1;
            if (dc_r == 3'd3) begin cp = acc_nxt; phase_nxt = PH_BODY; end
          end else begin
            rs[0] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0);
            n = 3'd1; phase_nxt = PH_BODY; go = 1'b1;
          end
        end
        PH_BRACE: begin
          if (b == 8'h7D) begin
            phase_nxt = PH_BODY;
            if (bf_r || dc_r == 3'd0 || dc_r > 3'd6) begin
              rs[0] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0); n = 3'd1;
            end else cp = acc_r;
            if (!(bf_r || dc_r == 3'd0 || dc_r > 3'd6) && acc_r == 24'd0) begin
              rs[0] = mk(KIND_BYTE, 8'd0, ERR_NONE, raw_r, 1'b0); n = 3'd1;
            end
          end else begin
            if (!bf_r && h[4]) begin
              if (dc_r < 3'd6) acc_nxt = {acc_r[19:0], h[3:0]};
              if (dc_r < 3'd7) dc_nxt = dc_r + 3'd1;
            end else begin
              if (!bf_r) begin
                rs[n] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0);
                n = n + 3'd1; bf_nxt = 1'b1;
              end
              if (b == 8'h22) begin
                rs[n] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0);
                n = n + 3'd1; phase_nxt = PH_BODY; go = 1'b1;
              end
            end
          end
        end
        default: go = 1'b1;
      endcase

      // codepoint to utf-8 (a zero codepoint from \u0000 comes here too)
      if (phase_r == PH_U4 || phase_r == PH_USTART) begin
        if (h[4] && dc_r == 3'd3 && !(phase_r == PH_USTART && b == 8'h7B)) begin
          rs[0] = mk(KIND_BYTE, {1'b0, cp[6:0]}, ERR_NONE, raw_r, 1'b0); n = 3'd1;
        end
      end
      if (cp != 24'd0 || (n == 3'd1 && rs[0].kind == KIND_BYTE && phase_nxt == PH_BODY
          && (phase_r == PH_U4 || phase_r == PH_USTART))) begin
        if (cp < 24'h80) begin
          rs[0] = mk(KIND_BYTE, {1'b0, cp[6:0]}, ERR_NONE, raw_r, 1'b0); n = 3'd1;
        end else if (cp < 24'h800) begin
          rs[0] = mk(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NONE, raw_r, 1'b0);
          rs[1] = mk(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE, raw_r, 1'b0); n = 3'd2;
        end else if (cp < 24'h10000) begin
          rs[0] = mk(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NONE, raw_r, 1'b0);
          rs[1] = mk(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE, raw_r, 1'b0);
          rs[2] = mk(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE, raw_r, 1'b0); n = 3'd3;
        end else if (cp <= 24'h10FFFF) begin
          rs[0] = mk(KIND_BYTE, {5'b11110, cp[20:18]}, ERR_NONE, raw_r, 1'b0);
          rs[1] = mk(KIND_BYTE, {2'b10, cp[17:12]}, ERR_NONE, raw_r, 1'b0);
          rs[2] = mk(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NONE, raw_r, 1'b0);
          rs[3] = mk(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NONE, raw_r, 1'b0); n = 3'd4;
        end else begin
          rs[0] = mk(KIND_ERR, 8'd0, ERR_UNICODE, raw_r, 1'b0); n = 3'd1;
        end
      end

      // ordinary body byte with utf-8 checking
      if (go) begin
        logic taken;
        taken = 1'b0;
        if (held_r != 2'd0) begin
          if (held_r == 2'd1) begin
            if (sb_r[0] == 8'hE0) lo = 8'hA0;
            else if (sb_r[0] == 8'hED) hi = 8'h9F;
            else if (sb_r[0] == 8'hF0) lo = 8'h90;
            else if (sb_r[0] == 8'hF4) hi = 8'h8F;
          end
          if (b >= lo && b <= hi) begin
            taken = 1'b1;
            if (held_r >= need_r) begin
              for (int i = 0; i < 3; i++)
                if (2'(i) < held_r) begin
                  rs[n] = mk(KIND_BYTE, sb_r[i], ERR_NONE, raw_r, 1'b0);
                  n = n + 3'd1;
                end
              rs[n] = mk(KIND_BYTE, b, ERR_NONE, raw_r, 1'b0);
              n = n + 3'd1;
              held_nxt = 2'd0; need_nxt = 2'd0;
            end else begin
              sb_nxt[held_r] = b;
              held_nxt = held_r + 2'd1;
            end
          end else begin
            for (int i = 0; i < 3; i++)
              if (2'(i) < held_r) begin
                rs[n] = mk(KIND_ERR, 8'd0, ERR_UTF8, raw_r, 1'b0);
                n = n + 3'd1;
              end
            held_nxt = 2'd0; need_nxt = 2'd0;
          end
        end
        if (!taken) begin
          if (b == 8'h22) begin
            rs[n] = mk(KIND_END, 8'd0, ERR_NONE, raw_r, 1'b1);
            n = n + 3'd1; phase_nxt = PH_IDLE;
          end else if (!raw_r && b == 8'h5C) phase_nxt = PH_ESC;
          else if (b < 8'h80) begin
            rs[n] = mk(KIND_BYTE, b, ERR_NONE, raw_r, 1'b0); n = n + 3'd1;
          end else if (b >= 8'hC2 && b <= 8'hF4) begin
            sb_nxt[0] = b; held_nxt = 2'd1;
            need_nxt = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
          end else begin
            rs[n] = mk(KIND_ERR, 8'd0, ERR_UTF8, raw_r, 1'b0); n = n + 3'd1;
          end
        end
      end
    end

    for (int i = 0; i < MaxRes; i++)
      if (3'(i) == n - 3'd1) rs[i].last = 1'b1;
  end

  assign grp.count = in_push ? n : 3'd0;
  assign grp.res   = rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; raw_r <= 1'b0; acc_r <= '0; dc_r <= '0; bf_r <= 1'b0;
      need_r <= '0; held_r <= '0;
    end else if (in_push) begin
      phase_r <= phase_nxt; raw_r <= raw_nxt; acc_r <= acc_nxt; dc_r <= dc_nxt;
      bf_r <= bf_nxt; need_r <= need_nxt; held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push) sb_r <= sb_nxt;
  end

endmodule

FILE: rtl/slu_back.sv
// back end: queue of result groups, unpacked one result per pop
module slu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  slu_pkg::group_t grp,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output slu_pkg::res_t   head
);
  import slu_pkg::*;

  localparam int AW = $clog2(QDepth);

  group_t          q_r [QDepth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic [2:0]      sub_r;
  logic            wr, rd_grp;

  assign full   = cnt_r >= (AW+1)'(QDepth - 1);
  assign empty  = cnt_r == '0;
  assign head   = q_r[rp_r].res[sub_r];
  assign wr     = grp.count != 3'd0;
  assign rd_grp = pop && !empty && (sub_r == q_r[rp_r].count - 3'd1);

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + AW'(1);
      if (rd_grp) begin
        rp_r <= rp_r + AW'(1); sub_r <= '0;
      end else if (pop && !empty) sub_r <= sub_r + 3'd1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd_grp);
    end
  end

endmodule

FILE: rtl/string_literal_unescape.sv
// String literal unescaper: one source byte accepted per cycle while full is low;
// each byte is decoded combinationally and its results, up to six, go into an
// eight-group queue (a byte with no results writes nothing), read out one result
// per pop; full rises when seven groups are waiting.
module string_literal_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_raw_flag,
  output logic       out_terminated,
  output logic       out_last
);
  import slu_pkg::*;
  `include "string_literal_unescape_macros.svh"

  group_t grp;
  res_t   head;
  logic   acc;

  assign acc = in_push && !in_full;

  slu_front u_front (
    .clk, .rst_n, .in_push(acc), .in_byte, .end_of_input(in_end_of_input), .grp
  );

  slu_back u_back (
    .clk, .rst_n, .grp, .full(in_full), .empty(out_empty), .pop(out_pop), .head
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.byte_v;
  assign out_error_code = head.err;
  assign out_raw_flag   = head.raw;
  assign out_terminated = head.term;
  assign out_last       = head.last;

  `SLU_ASSERT_ALWAYS(a_count, clk, rst_n, grp.count <= 3'(MaxRes))
  `SLU_ASSERT_ALWAYS(a_kind, clk, rst_n, out_empty || out_kind != 2'd3)
  `SLU_ASSERT_NEXT(a_fill, clk, rst_n, acc && grp.count != 3'd0, !out_empty)

endmodule

FILE: sim/slu_checker.sv
// result checker for the string literal unescaper: predicts and compares beats
`timescale 1ns / 100ps
module slu_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_error_code,
  input  logic       out_raw_flag,
  input  logic       out_terminated,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);
  import slu_pkg::*;

  typedef enum int {
    S_IDLE, S_RSEEN, S_BODY, S_ESC, S_HEX, S_USTART, S_U4, S_BRACE
  } lit_state_t;

  lit_state_t  lit_state;
  logic        raw_lit;
  logic [23:0] code_acc;
  int          ndigits;
  logic        brace_bad;
  logic [7:0]  utf_buf [3];
  int          utf_need;
  int          utf_held;

  res_t decoded_q[$];
  res_t step_q[$];

  assign pending = decoded_q.size();

  function automatic res_t make_res(logic [1:0] k, logic [7:0] b, logic [2:0] e,
                                    logic t);
    res_t r;
    r.kind = k; r.byte_v = b; r.err = e; r.raw = raw_lit; r.term = t; r.last = 1'b0;
    return r;
  endfunction

  task automatic put(logic [1:0] k, logic [7:0] b, logic [2:0] e, logic t);
    if (step_q.size() < MaxRes) step_q.push_back(make_res(k, b, e, t));
  endtask

  function automatic int hexdig(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - 8'h30);
    if (b >= "a" && b <= "f") return int'(b - 8'h57);
    if (b >= "A" && b <= "F") return int'(b - 8'h37);
    return -1;
  endfunction

  task automatic put_code(logic [23:0] cp);
    if (cp < 24'h80) begin
      put(KIND_BYTE, cp[7:0], ERR_NONE, 1'b0);
    end else if (cp < 24'h800) begin
      put(KIND_BYTE, 8'hC0 | cp[10:6], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[5:0], ERR_NONE, 1'b0);
    end else if (cp < 24'h10000) begin
      put(KIND_BYTE, 8'hE0 | cp[15:12], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[11:6], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[5:0], ERR_NONE, 1'b0);
    end else if (cp <= 24'h10FFFF) begin
      put(KIND_BYTE, 8'hF0 | cp[20:18], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[17:12], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[11:6], ERR_NONE, 1'b0);
      put(KIND_BYTE, 8'h80 | cp[5:0], ERR_NONE, 1'b0);
    end else begin
      put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
    end
  endtask

  task automatic flush_utf;
    for (int i = 0; i < utf_held; i++) put(KIND_ERR, 8'd0, ERR_UTF8, 1'b0);
    utf_held = 0;
    utf_need = 0;
  endtask

  task automatic idle_take(logic [7:0] b);
    if (b == "\"") begin
      raw_lit = 1'b0;
      lit_state = S_BODY;
    end else if (b == "r") begin
      raw_lit = 1'b1;
      lit_state = S_RSEEN;
    end
  endtask

  task automatic body_take(logic [7:0] b);
    logic [7:0] lo, hi;
    if (utf_held > 0) begin
      lo = 8'h80;
      hi = 8'hBF;
      if (utf_held == 1) begin
        case (utf_buf[0])
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        if (utf_held >= utf_need) begin
          for (int i = 0; i < utf_held && i < 3; i++)
            put(KIND_BYTE, utf_buf[i], ERR_NONE, 1'b0);
          put(KIND_BYTE, b, ERR_NONE, 1'b0);
          utf_held = 0;
          utf_need = 0;
        end else begin
          utf_buf[utf_held] = b;
          utf_held++;
        end
        return;
      end
      flush_utf();
    end
    if (b == "\"") begin
      put(KIND_END, 8'd0, ERR_NONE, 1'b1);
      lit_state = S_IDLE;
    end else if (!raw_lit && b == "\\") begin
      lit_state = S_ESC;
    end else if (b < 8'h80) begin
      put(KIND_BYTE, b, ERR_NONE, 1'b0);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      utf_buf[0] = b;
      utf_held = 1;
      utf_need = (b < 8'hE0) ? 1 : (b < 8'hF0) ? 2 : 3;
    end else begin
      put(KIND_ERR, 8'd0, ERR_UTF8, 1'b0);
    end
  endtask

  task automatic close_open;
    flush_utf();
    put(KIND_ERR, 8'd0, ERR_UNTERM, 1'b0);
    put(KIND_END, 8'd0, ERR_NONE, 1'b0);
    lit_state = S_IDLE;
  endtask

  task automatic begin_digits(lit_state_t s);
    lit_state = s;
    code_acc = '0;
    ndigits = 0;
    brace_bad = 1'b0;
  endtask

  task automatic predict_beat(logic [7:0] b, logic eoi);
    int h;
    step_q.delete();
    if (eoi) begin
      case (lit_state)
        S_IDLE: ;
        S_RSEEN: begin
          put(KIND_ERR, 8'd0, ERR_RQUOTE, 1'b0);
          put(KIND_END, 8'd0, ERR_NONE, 1'b0);
          lit_state = S_IDLE;
        end
        S_HEX: begin
          if (ndigits == 0) put(KIND_ERR, 8'd0, ERR_HEX, 1'b0);
          else put(KIND_BYTE, code_acc[7:0], ERR_NONE, 1'b0);
          close_open();
        end
        S_USTART, S_U4, S_BRACE: begin
          put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
          close_open();
        end
        default: close_open();
      endcase
    end else begin
      case (lit_state)
        S_IDLE: idle_take(b);
        S_RSEEN: begin
          if (b == "\"") begin
            lit_state = S_BODY;
          end else begin
            put(KIND_ERR, 8'd0, ERR_RQUOTE, 1'b0);
            put(KIND_END, 8'd0, ERR_NONE, 1'b0);
            lit_state = S_IDLE;
            idle_take(b);
          end
        end
        S_ESC: begin
          lit_state = S_BODY;
          case (b)
            "n": put(KIND_BYTE, 8'h0A, ERR_NONE, 1'b0);
            "t": put(KIND_BYTE, 8'h09, ERR_NONE, 1'b0);
            "r": put(KIND_BYTE, 8'h0D, ERR_NONE, 1'b0);
            "\\", "\"", "'": put(KIND_BYTE, b, ERR_NONE, 1'b0);
            "0": put(KIND_BYTE, 8'h00, ERR_NONE, 1'b0);
            "x": begin_digits(S_HEX);
            "u": begin_digits(S_USTART);
            default: begin
              put(KIND_ERR, 8'd0, ERR_ESCAPE, 1'b0);
              put(KIND_BYTE, b, ERR_NONE, 1'b0);
            end
          endcase
        end
        S_HEX: begin
          h = hexdig(b);
          if (h >= 0) begin
            code_acc = {16'd0, code_acc[3:0], h[3:0]};
            ndigits++;
            if (ndigits >= 2) begin
              put(KIND_BYTE, code_acc[7:0], ERR_NONE, 1'b0);
              lit_state = S_BODY;
            end
          end else begin
            if (ndigits == 0) put(KIND_ERR, 8'd0, ERR_HEX, 1'b0);
            else put(KIND_BYTE, code_acc[7:0], ERR_NONE, 1'b0);
            lit_state = S_BODY;
            body_take(b);
          end
        end
        S_USTART, S_U4: begin
          if (lit_state == S_USTART && b == "{") begin
            begin_digits(S_BRACE);
          end else begin
            lit_state = S_U4;
            h = hexdig(b);
            if (h >= 0) begin
              code_acc = {8'd0, code_acc[11:0], h[3:0]};
              ndigits++;
              if (ndigits >= 4) begin
                put_code(code_acc);
                lit_state = S_BODY;
              end
            end else begin
              put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
              lit_state = S_BODY;
              body_take(b);
            end
          end
        end
        S_BRACE: begin
          h = hexdig(b);
          if (b == "}") begin
            if (brace_bad || ndigits == 0 || ndigits > 6)
              put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
            else put_code(code_acc);
            lit_state = S_BODY;
          end else if (!brace_bad && h >= 0) begin
            if (ndigits < 6) code_acc = {code_acc[19:0], h[3:0]};
            if (ndigits < 7) ndigits++;
          end else begin
            if (!brace_bad) begin
              put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
              brace_bad = 1'b1;
            end
            if (b == "\"") begin
              put(KIND_ERR, 8'd0, ERR_UNICODE, 1'b0);
              lit_state = S_BODY;
              body_take(b);
            end
          end
        end
        default: body_take(b);
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  res_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      lit_state = S_IDLE;
      raw_lit = 1'b0;
      code_acc = '0;
      ndigits = 0;
      brace_bad = 1'b0;
      utf_need = 0;
      utf_held = 0;
      decoded_q.delete();
      fail_count <= 0;
    end else begin
      // results first: a beat popped now was predicted on an earlier edge
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result beat kind=%0d", out_kind);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_kind !== exp_r.kind || out_byte !== exp_r.byte_v ||
              out_error_code !== exp_r.err || out_raw_flag !== exp_r.raw ||
              out_terminated !== exp_r.term || out_last !== exp_r.last) begin
            if (out_kind !== exp_r.kind)
              $error("kind expected %0d actual %0d", exp_r.kind, out_kind);
            if (out_byte !== exp_r.byte_v)
              $error("out_byte expected %0h actual %0h", exp_r.byte_v, out_byte);
            if (out_error_code !== exp_r.err)
              $error("error_code expected %0d actual %0d", exp_r.err, out_error_code);
            if (out_raw_flag !== exp_r.raw)
              $error("raw_flag expected %0d actual %0d", exp_r.raw, out_raw_flag);
            if (out_terminated !== exp_r.term)
              $error("terminated expected %0d actual %0d", exp_r.term, out_terminated);
            if (out_last !== exp_r.last)
              $error("last expected %0d actual %0d", exp_r.last, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full) predict_beat(in_byte, in_end_of_input);
    end
  end

endmodule

FILE: sim/tb_top.sv
// testbench top for the string literal unescaper: stimulus, reset and verdict
`timescale 1ns / 100ps
module tb_top;
  import slu_pkg::*;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_push = 0;
  logic       in_full;
  logic [7:0] in_byte = 0;
  logic       in_end_of_input = 0;
  logic       out_empty;
  logic       out_pop = 0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_error_code;
  logic       out_raw_flag;
  logic       out_terminated;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         stall_mode = 0;

  string_literal_unescape dut (.*);

  slu_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: switches between no stalls, light stalls and heavy stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      default: out_pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  logic [8:0] src_q[$];   // bit 8 marks end of source
  int         burst_left = 0;

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
  endtask

  task automatic add_b(logic [7:0] b);
    src_q.push_back({1'b0, b});
  endtask

  function automatic logic [7:0] rand_hex();
    string d = "0123456789abcdefABCDEF";
    return d[$urandom_range(0, 21)];
  endfunction

  // a random well-formed or slightly broken piece of literal body
  task automatic add_piece();
    int sel;
    logic [7:0] lead;
    logic [7:0] pick;
    string esc_chars;
    esc_chars = "ntr\\\"'0q";
    sel = $urandom_range(0, 13);
    case (sel)
      0, 1: begin
        pick = 8'($urandom_range(8'h20, 8'h7E));
        add_b(pick == "\"" ? "a" : pick);
      end
      2: add_b(8'($urandom_range(0, 255)));
      3: begin
        add_b(8'($urandom_range(8'hC2, 8'hDF)));
        add_b(8'($urandom_range(8'h80, 8'hBF)));
      end
      4: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        add_b(lead);
        add_b(lead == 8'hE0 ? 8'($urandom_range(8'hA0, 8'hBF)) :
              lead == 8'hED ? 8'($urandom_range(8'h80, 8'h9F)) :
                              8'($urandom_range(8'h80, 8'hBF)));
        add_b(8'($urandom_range(8'h80, 8'hBF)));
      end
      5: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        add_b(lead);
        add_b(lead == 8'hF0 ? 8'($urandom_range(8'h90, 8'hBF)) :
              lead == 8'hF4 ? 8'($urandom_range(8'h80, 8'h8F)) :
                              8'($urandom_range(8'h80, 8'hBF)));
        add_b(8'($urandom_range(8'h80, 8'hBF)));
        add_b(8'($urandom_range(8'h80, 8'hBF)));
      end
      6: begin
        add_b("\\");
        if ($urandom_range(0, 1) != 0) add_b(esc_chars[$urandom_range(0, 7)]);
        else add_b(8'($urandom_range(0, 255)));
      end
      7: begin
        add_str("\\x");
        for (int i = $urandom_range(0, 3); i > 0; i--) add_b(rand_hex());
      end
      8: begin
        add_str("\\u");
        for (int i = $urandom_range(0, 4); i > 0; i--) add_b(rand_hex());
      end
      9, 10: begin
        add_str("\\u{");
        for (int i = $urandom_range(0, 7); i > 0; i--)
          add_b($urandom_range(0, 9) == 0 ? "g" : rand_hex());
        if ($urandom_range(0, 5) != 0) add_b("}");
      end
      11: add_str("\\u{10FFFF}");
      12: add_b(8'($urandom_range(8'h80, 8'hC1)));
      default: add_b(8'($urandom_range(8'hF5, 8'hFF)));
    endcase
  endtask

  task automatic add_literal();
    logic raw;
    raw = ($urandom_range(0, 3) == 0);
    if (raw) add_str("r");
    if ($urandom_range(0, 15) != 0) add_b("\"");
    else add_b(8'($urandom_range(0, 255)));
    for (int i = $urandom_range(0, 5); i > 0; i--) add_piece();
    case ($urandom_range(0, 9))
      0: src_q.push_back(9'h100);
      1: ;
      default: add_b("\"");
    endcase
    if ($urandom_range(0, 3) == 0) add_b(8'($urandom_range(0, 255)));
  endtask

  task automatic send_all();
    int gap;
    while (src_q.size() > 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      in_push <= 1'b1;
      {in_end_of_input, in_byte} <= src_q[0];
      @(posedge clk);
      while (in_full) @(posedge clk);
      void'(src_q.pop_front());
      burst_left--;
    end
    in_push <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed literals
    add_str("\"A\\n\\t\\r\\\\\\\"\\'\\0\\q\"");
    add_str("\"\\x4\\xg\\xFF\\u00e9\\uD800\\u12z\"");
    add_str("\"\\u{1F600}\\u{}\\u{1234567}\\u{110000}\\u{1g2}\\u{zz\"");
    add_str("r\"a\\b\"rx");
    add_b("\""); add_b(8'hE0); add_b(8'h80); add_b(8'hF4); add_b(8'h90);
    add_b(8'hC0); add_b(8'hFF); add_b(8'h00); add_b(8'hC3); add_b(8'hA9);
    src_q.push_back(9'h100);
    add_str("r");
    src_q.push_back(9'h100);
    add_str("\"\\x7");
    src_q.push_back(9'h100);
    add_str("\"\\x");
    src_q.push_back(9'h100);
    add_str("\"\\u{1");
    src_q.push_back(9'h100);
    src_q.push_back(9'h100);
    send_all();

    // hold off until the queue has drained
    while (pending != 0) @(posedge clk);

    while (src_q.size() < 150) add_literal();
    send_all();

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
